@@ rtl/core/gradient_orientation_quantizer_core_defines.svh @@
// Assertion macros shared by the gradient orientation quantizer RTL.
`ifndef GRADIENT_ORIENTATION_QUANTIZER_CORE_DEFINES_SVH
`define GRADIENT_ORIENTATION_QUANTIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define GOQZ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("goqz: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define GOQZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("goqz: next-cycle check failed");

`endif

@@ rtl/core/goqz_pkg.sv @@
// Types and constants of the gradient orientation quantizer.
package goqz_pkg;

  localparam int NUM_CHAN = 3;
  localparam int CHAN_W   = 8;
  localparam int PIXEL_W  = NUM_CHAN * CHAN_W;
  localparam int GRAD_W   = 11;   // h and v lie in -1020..1020
  localparam int MAG_W    = 22;   // h*h + v*v stays below 2^21
  localparam int ABS_W    = 10;   // |h| and |v| stay at or below 1020
  localparam int PROJ_W   = 27;   // largest projection stays below 2^27
  localparam int FRAC_W   = 16;   // Q0.16 coefficients

  typedef logic [PIXEL_W-1:0]       pixel_t;
  typedef logic [CHAN_W-1:0]        chan_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [ABS_W-1:0]         absv_t;
  typedef logic [PROJ_W-1:0]        proj_t;
  typedef logic [3:0]               orient_t;

  // Projection coefficients in Q0.16, rounded to nearest.
  localparam proj_t COEF_COS18 = proj_t'(62328);  // 0.9510565
  localparam proj_t COEF_SIN18 = proj_t'(20252);  // 0.3090170
  localparam proj_t COEF_COS54 = proj_t'(38521);  // 0.5877852
  localparam proj_t COEF_SIN54 = proj_t'(53020);  // 0.8090170

  // First bin of each quadrant and the bin range.
  localparam orient_t ORIENT_MIN  = 4'd1;
  localparam orient_t ORIENT_MAX  = 4'd10;
  localparam orient_t ORIENT_QUAD1 = 4'd1;
  localparam orient_t ORIENT_QUAD2 = 4'd3;
  localparam orient_t ORIENT_QUAD3 = 4'd6;
  localparam orient_t ORIENT_QUAD4 = 4'd8;

  typedef struct packed {
    pixel_t nw;
    pixel_t n;
    pixel_t ne;
    pixel_t w;
    pixel_t e;
    pixel_t sw;
    pixel_t s;
    pixel_t se;
  } window_t;

  // Quadrant decision handed from the channel pick to the binning stage.
  typedef struct packed {
    logic    swap;   // vertical projection is tried first, diagonal last
    orient_t base;   // first bin of the quadrant
  } bin_ctl_t;

endpackage

@@ rtl/core/goqz_if.sv @@
// Handshake channels of the gradient orientation quantizer.
interface goqz_win_if;
  import goqz_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_nw;
  pixel_t pixel_n;
  pixel_t pixel_ne;
  pixel_t pixel_w;
  pixel_t pixel_e;
  pixel_t pixel_sw;
  pixel_t pixel_s;
  pixel_t pixel_se;

  modport source (output valid, pixel_nw, pixel_n, pixel_ne, pixel_w, pixel_e,
                  pixel_sw, pixel_s, pixel_se, input ready);
  modport sink (input valid, pixel_nw, pixel_n, pixel_ne, pixel_w, pixel_e,
                pixel_sw, pixel_s, pixel_se, output ready);
endinterface

interface goqz_res_if;
  import goqz_pkg::*;

  logic    valid;
  logic    ready;
  orient_t orientation;

  modport source (output valid, orientation, input ready);
  modport sink (input valid, orientation, output ready);
endinterface

@@ rtl/core/goqz_grad.sv @@
// Per-channel Sobel sums and squared magnitudes, registered.
module goqz_grad (
  input  logic             clk,
  input  logic             en,
  input  goqz_pkg::window_t win,
  output goqz_pkg::grad_t  h_r [goqz_pkg::NUM_CHAN],
  output goqz_pkg::grad_t  v_r [goqz_pkg::NUM_CHAN],
  output goqz_pkg::mag_t   m_r [goqz_pkg::NUM_CHAN]
);
  import goqz_pkg::*;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    grad_t nw, n, ne, w, e, sw, s, se;
    grad_t h_nxt, v_nxt;
    logic signed [MAG_W-1:0] hh, vv;
    mag_t  m_nxt;

    always_comb begin
      nw = grad_t'({3'b000, win.nw[c*CHAN_W +: CHAN_W]});
      n  = grad_t'({3'b000, win.n [c*CHAN_W +: CHAN_W]});
      ne = grad_t'({3'b000, win.ne[c*CHAN_W +: CHAN_W]});
      w  = grad_t'({3'b000, win.w [c*CHAN_W +: CHAN_W]});
      e  = grad_t'({3'b000, win.e [c*CHAN_W +: CHAN_W]});
      sw = grad_t'({3'b000, win.sw[c*CHAN_W +: CHAN_W]});
      s  = grad_t'({3'b000, win.s [c*CHAN_W +: CHAN_W]});
      se = grad_t'({3'b000, win.se[c*CHAN_W +: CHAN_W]});
      h_nxt = nw + (n <<< 1) + ne - sw - (s <<< 1) - se;
      v_nxt = nw + (w <<< 1) + sw - ne - (e <<< 1) - se;
      hh    = MAG_W'(h_nxt) * MAG_W'(h_nxt);
      vv    = MAG_W'(v_nxt) * MAG_W'(v_nxt);
      m_nxt = $unsigned(hh) + $unsigned(vv);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        h_r[c] <= h_nxt;
        v_r[c] <= v_nxt;
        m_r[c] <= m_nxt;
      end
    end
  end
endmodule

@@ rtl/core/goqz_pick.sv @@
// Strongest-channel pick, absolute values and quadrant decision, registered.
module goqz_pick (
  input  logic               clk,
  input  logic               en,
  input  goqz_pkg::grad_t    h [goqz_pkg::NUM_CHAN],
  input  goqz_pkg::grad_t    v [goqz_pkg::NUM_CHAN],
  input  goqz_pkg::mag_t     m [goqz_pkg::NUM_CHAN],
  output goqz_pkg::absv_t    ha_r,
  output goqz_pkg::absv_t    va_r,
  output goqz_pkg::bin_ctl_t ctl_r
);
  import goqz_pkg::*;

  grad_t    h_best, v_best, h_abs, v_abs;
  mag_t     m_best;
  logic     h_neg, v_neg;
  bin_ctl_t ctl_nxt;

  always_comb begin
    // A later channel wins only with a strictly larger magnitude.
    h_best = h[0];
    v_best = v[0];
    m_best = m[0];
    for (int c = 1; c < NUM_CHAN; c++) begin
      if (m[c] > m_best) begin
        h_best = h[c];
        v_best = v[c];
        m_best = m[c];
      end
    end

    h_neg = h_best[GRAD_W-1];
    v_neg = v_best[GRAD_W-1];
    h_abs = h_neg ? -h_best : h_best;
    v_abs = v_neg ? -v_best : v_best;

    // Quadrants are tried in order; zero components fall to the earlier one.
    if (!h_neg && !v_neg) begin
      ctl_nxt = '{swap: 1'b0, base: ORIENT_QUAD1};
    end else if (!v_neg) begin
      ctl_nxt = '{swap: 1'b1, base: ORIENT_QUAD2};
    end else if (h_neg || (h_best == '0)) begin
      ctl_nxt = '{swap: 1'b0, base: ORIENT_QUAD3};
    end else begin
      ctl_nxt = '{swap: 1'b1, base: ORIENT_QUAD4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ha_r  <= h_abs[ABS_W-1:0];
      va_r  <= v_abs[ABS_W-1:0];
      ctl_r <= ctl_nxt;
    end
  end
endmodule

@@ rtl/core/goqz_bin.sv @@
// Projection products (registered) and the bin decision that follows them.
module goqz_bin (
  input  logic               clk,
  input  logic               en,
  input  goqz_pkg::absv_t    ha,
  input  goqz_pkg::absv_t    va,
  input  goqz_pkg::bin_ctl_t ctl,
  output goqz_pkg::orient_t  orientation
);
  import goqz_pkg::*;

  proj_t    diag18_r, diag54_r, vert_r;
  bin_ctl_t ctl_r;
  proj_t    diag18_nxt, diag54_nxt, vert_nxt;
  proj_t    first, last, best;
  logic [1:0] sel;

  always_comb begin
    diag18_nxt = proj_t'(ha) * COEF_COS18 + proj_t'(va) * COEF_SIN18;
    diag54_nxt = proj_t'(ha) * COEF_COS54 + proj_t'(va) * COEF_SIN54;
    vert_nxt   = proj_t'(va) << FRAC_W;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diag18_r <= diag18_nxt;
      diag54_r <= diag54_nxt;
      vert_r   <= vert_nxt;
      ctl_r    <= ctl;
    end
  end

  // Three candidates in bin order; strict compares keep the earlier bin on a tie.
  always_comb begin
    first = ctl_r.swap ? vert_r : diag18_r;
    last  = ctl_r.swap ? diag18_r : vert_r;
    sel   = 2'd0;
    best  = first;
    if (diag54_r > best) begin
      sel  = 2'd1;
      best = diag54_r;
    end
    if (last > best) begin
      sel = 2'd2;
    end
    orientation = ctl_r.base + orient_t'(sel);
  end
endmodule

@@ rtl/core/gradient_orientation_quantizer_core.sv @@
// Top level of the gradient orientation quantizer.
//
// The core takes the eight neighbours of one pixel of an RGB image per item
// and returns one orientation bin, 1 to 10 around the circle, per item. For
// each of the three 8-bit channels it forms h (top row minus bottom row) and
// v (left column minus right column) with 1,2,1 weights, keeps the channel
// with the largest h*h + v*v (the lower channel wins a tie), and places (h,v)
// into a bin by a quadrant test and strict compares of Q0.16 projections.
// The datapath is a five-register pipeline: input window, channel sums and
// magnitudes, channel pick with quadrant, projection products, and the
// result register. An item is accepted whenever the first stage can move,
// and its result passes through the later registers in order. Throughput
// is one item per clock while the result side takes items; when it stalls,
// the pipeline fills bubbles first and then holds, and in_win.ready follows
// the stall back through the stages in the same cycle.
`include "gradient_orientation_quantizer_core_defines.svh"

module gradient_orientation_quantizer_core (
  input logic        clk,
  input logic        rst_n,
  goqz_win_if.sink   in_win,
  goqz_res_if.source out_res
);
  import goqz_pkg::*;

  // Stage valid bits; each stage moves when it is empty or its successor moves.
  logic v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic en0, en1, en2, en3, en_out;

  window_t  window_r;
  grad_t    h_s1 [NUM_CHAN];
  grad_t    v_s1 [NUM_CHAN];
  mag_t     m_s1 [NUM_CHAN];
  absv_t    ha_s2, va_s2;
  bin_ctl_t ctl_s2;
  orient_t  orient_s3;
  orient_t  out_orient_r;

  assign en_out = !out_valid_r || out_res.ready;
  assign en3    = !v3_r || en_out;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign en0    = !v0_r || en1;

  // No item is taken while reset is held, since in_win.ready is gated with rst_n.
  assign in_win.ready        = en0 && rst_n;
  assign out_res.valid       = out_valid_r;
  assign out_res.orientation = out_orient_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en0)    v0_r        <= in_win.valid;
      if (en1)    v1_r        <= v0_r;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en_out) out_valid_r <= v3_r;
    end
  end

  // Input window register; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (en0) begin
      window_r <= '{nw: in_win.pixel_nw, n: in_win.pixel_n, ne: in_win.pixel_ne,
                    w: in_win.pixel_w, e: in_win.pixel_e, sw: in_win.pixel_sw,
                    s: in_win.pixel_s, se: in_win.pixel_se};
    end
  end

  goqz_grad u_grad (
    .clk (clk),
    .en  (en1),
    .win (window_r),
    .h_r (h_s1),
    .v_r (v_s1),
    .m_r (m_s1)
  );

  goqz_pick u_pick (
    .clk   (clk),
    .en    (en2),
    .h     (h_s1),
    .v     (v_s1),
    .m     (m_s1),
    .ha_r  (ha_s2),
    .va_r  (va_s2),
    .ctl_r (ctl_s2)
  );

  goqz_bin u_bin (
    .clk         (clk),
    .en          (en3),
    .ha          (ha_s2),
    .va          (va_s2),
    .ctl         (ctl_s2),
    .orientation (orient_s3)
  );

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_orient_r <= orient_s3;
    end
  end

  // A delivered bin always lies in the legal range.
  `GOQZ_ASSERT_IMPLY(a_orient_range, clk, rst_n, out_valid_r, (out_orient_r >= ORIENT_MIN) && (out_orient_r <= ORIENT_MAX))
  // With the result side open the whole pipeline advances, so in_win.ready is high.
  `GOQZ_ASSERT_IMPLY(a_ready_when_drained, clk, rst_n, out_res.ready, in_win.ready)
  // An item in the projection stage reaches the result register when it moves.
  `GOQZ_ASSERT_NEXT(a_last_stage_moves, clk, rst_n, v3_r && en_out, out_valid_r)
  // Quadrant base is always one of the four first bins.
  `GOQZ_ASSERT_IMPLY(a_quad_base, clk, rst_n, v2_r, (ctl_s2.base == ORIENT_QUAD1) || (ctl_s2.base == ORIENT_QUAD2) || (ctl_s2.base == ORIENT_QUAD3) || (ctl_s2.base == ORIENT_QUAD4))

endmodule
